>>> hw/rtl/ssfb_pkg.sv
// Package: constants, command codes and sequencer states of the seven-segment frame buffer.
package ssfb_pkg;

  // Grid geometry
  localparam int DigitsPerRow  = 6;
  localparam int Rows          = 4;
  localparam int GridDepth     = DigitsPerRow * Rows;
  localparam int GridIdxW      = $clog2(GridDepth);

  // Driver unit geometry: one unit per pair of rows, twelve digit lanes per unit
  localparam int DigitsPerUnit = 2 * DigitsPerRow;
  localparam int LaneNum       = 12;
  localparam int LanesUsed     = (DigitsPerUnit < LaneNum) ? DigitsPerUnit : LaneNum;
  localparam int RamBytes      = 16;
  localparam int AddrW         = 4;
  localparam int MaxUnits      = 2;
  localparam int NumUnits      = ((Rows / 2) < MaxUnits) ? (Rows / 2) : MaxUnits;

  typedef logic [7:0] pattern_t;

  // Command codes
  typedef enum logic [2:0] {
    CmdSet      = 3'd0,
    CmdOrBits   = 3'd1,
    CmdClrBits  = 3'd2,
    CmdClearAll = 3'd3,
    CmdFillAll  = 3'd4,
    CmdUpdate   = 3'd5
  } cmd_e;

  // Update sequencer states
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StLoad = 3'b010,
    StEmit = 3'b100
  } state_e;

endpackage

>>> hw/rtl/seven_segment_frame_buffer.sv
// Seven-segment frame buffer: digit grid, command decode and driver RAM image sequencer.
// Set, OR, clear-bits, clear-all and fill-all keep busy low.
// Update: one window load plus 16 bytes per driver unit (up to 2 units), with busy high
// throughout; the first byte strobes after the load and emit states, one byte a cycle between loads.
// Rate is set by the shared segment shifter over the 12-lane window, one byte per cycle outside load states.
// Reset clears the grid to all zero and returns the sequencer to idle; results never stall.
module seven_segment_frame_buffer
  import ssfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] command_i,
  input  logic [2:0] column_i,
  input  logic [1:0] row_i,
  input  logic [7:0] pattern_i,
  output logic       result_valid_o,
  output logic [1:0] unit_o,
  output logic [3:0] ram_address_o,
  output logic [7:0] ram_byte_o,
  output logic       last_o
);

  pattern_t grid_q [GridDepth];
  pattern_t grid_d [GridDepth];
  pattern_t win_q  [LaneNum];
  pattern_t win_d  [LaneNum];

  state_e           state_q, state_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             unit_q, unit_d;

  logic             valid_q, valid_d;
  logic [1:0]       unit_out_q, unit_out_d;
  logic [AddrW-1:0] addr_out_q, addr_out_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;

  logic                accept;
  logic                in_range;
  logic [GridIdxW-1:0] wr_idx;
  logic                unit_last;
  cmd_e                cmd;

  assign accept   = start && !busy;
  assign cmd      = cmd_e'(command_i);
  assign in_range = (32'(column_i) < DigitsPerRow) && (32'(row_i) < Rows);
  assign wr_idx   = GridIdxW'(32'(row_i) * DigitsPerRow + 32'(column_i));
  assign unit_last = (32'(unit_q) == NumUnits - 1);

  // Apply grid commands on an accepted transaction
  always_comb begin
    grid_d = grid_q;
    if (accept) begin
      unique case (cmd)
        CmdSet: begin
          if (in_range) grid_d[wr_idx] = pattern_i;
        end
        CmdOrBits: begin
          if (in_range) grid_d[wr_idx] = grid_q[wr_idx] | pattern_i;
        end
        CmdClrBits: begin
          if (in_range) grid_d[wr_idx] = grid_q[wr_idx] & ~pattern_i;
        end
        CmdClearAll: begin
          for (int i = 0; i < GridDepth; i++) grid_d[i] = '0;
        end
        CmdFillAll: begin
          for (int i = 0; i < GridDepth; i++) grid_d[i] = 8'hFF;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GridDepth; i++) grid_q[i] <= '0;
    end else begin
      grid_q <= grid_d;
    end
  end

  // Sequence the update: load a unit window, then shift out 16 bytes
  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    unit_d     = unit_q;
    win_d      = win_q;
    valid_d    = 1'b0;
    unit_out_d = unit_out_q;
    addr_out_d = addr_out_q;
    byte_d     = byte_q;
    last_d     = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (accept && cmd == CmdUpdate && NumUnits > 0) begin
          state_d = StLoad;
          addr_d  = '0;
          unit_d  = 1'b0;
        end
      end
      StLoad: begin
        // Each lane takes its digit of the current unit, unused lanes read zero
        for (int k = 0; k < LaneNum; k++) begin
          if (k < LanesUsed && (32'(unit_q) * DigitsPerUnit + k) < GridDepth) begin
            win_d[k] = grid_q[GridIdxW'(32'(unit_q) * DigitsPerUnit + k)];
          end else begin
            win_d[k] = '0;
          end
        end
        state_d = StEmit;
      end
      StEmit: begin
        // Gather the current segment (bit 7 of each lane) into bytes: lanes 0-7 on even, lanes 8-11 on odd addresses
        valid_d    = 1'b1;
        unit_out_d = 2'(unit_q);
        addr_out_d = addr_q;
        if (addr_q[0]) begin
          byte_d = {4'b0000, win_q[11][7], win_q[10][7], win_q[9][7], win_q[8][7]};
        end else begin
          byte_d = {win_q[7][7], win_q[6][7], win_q[5][7], win_q[4][7],
                    win_q[3][7], win_q[2][7], win_q[1][7], win_q[0][7]};
        end
        last_d = unit_last && (addr_q == AddrW'(RamBytes - 1));
        // Advance to the next segment after the odd byte
        if (addr_q[0]) begin
          for (int k = 0; k < LaneNum; k++) win_d[k] = {win_q[k][6:0], 1'b0};
        end
        addr_d = addr_q + 1'b1;
        if (addr_q == AddrW'(RamBytes - 1)) begin
          if (unit_last) begin
            state_d = StIdle;
          end else begin
            unit_d  = unit_q + 1'b1;
            state_d = StLoad;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      addr_q  <= '0;
      unit_q  <= 1'b0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      unit_q  <= unit_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  // Hold the window and result payload
  always_ff @(posedge clk_i) begin
    win_q      <= win_d;
    unit_out_q <= unit_out_d;
    addr_out_q <= addr_out_d;
    byte_q     <= byte_d;
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = valid_q;
  assign unit_o         = unit_out_q;
  assign ram_address_o  = addr_out_q;
  assign ram_byte_o     = byte_q;
  assign last_o         = last_q;

  // A result strobe follows only an emit cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == StEmit))
    else $error("result strobe without emit cycle");

  // The final flag marks only the top byte of a strobed transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> (result_valid_o && ram_address_o == AddrW'(RamBytes - 1)))
    else $error("last flag on wrong byte");

  // Odd addresses carry only four digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && ram_address_o[0]) |-> (ram_byte_o[7:4] == 4'b0000))
    else $error("upper nibble set on odd address");

  // Byte counter is parked at zero while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (addr_q == '0))
    else $error("byte counter not cleared in idle");

endmodule
